FILE: design/slm_pkg.sv
// Shared types and constants for the four-channel sound level monitor.
// No dependencies; used by the controller, datapath, divider and checker.
package slm_pkg;

  localparam int NUM_CH   = 4;
  localparam int SMP_W    = 12;
  localparam int LVL_W    = 8;
  localparam int LIM_W    = 6;
  localparam int SUM_W    = 14;
  localparam int CNT_W    = 7;
  localparam int DIR_W    = 3;
  localparam int PROD_W   = SMP_W + LVL_W;
  localparam int DSTEP_W  = $clog2(SUM_W);
  localparam int CFG_IDX_W = 3;

  // ADC code flagged as spurious; also the full-scale divisor
  localparam logic [SMP_W-1:0] SPURIOUS   = '1;
  localparam logic [SMP_W-1:0] FULL_SCALE = '1;

  // Config reset values
  localparam logic [LVL_W-1:0] FLOOR_RST   = 8'd30;
  localparam logic [LVL_W-1:0] CEILING_RST = 8'd150;
  localparam logic [LVL_W-1:0] LOUD_RST    = 8'd90;
  localparam logic [LIM_W-1:0] LIMIT_RST   = 6'd20;
  localparam logic [LIM_W-1:0] AVGDIV_RST  = 6'd30;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOUD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AVGDIV  = 3'd4;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_UNDECIDED = 3'd0;
  localparam logic [DIR_W-1:0] DIR_QUIET     = 3'd1;
  localparam logic [DIR_W-1:0] DIR_CH_BASE   = 3'd2;

  // Report kinds
  localparam logic KIND_WINDOW = 1'b0;
  localparam logic KIND_PERIOD = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // input beat accepted: update min/max
    logic mul;        // form peak-to-peak products, clear window
    logic lvl;        // scale products to levels
    logic sum;        // accumulate sums, loud count
    logic dir;        // direction and status decision
    logic load_win;   // load window report
    logic last;       // last flag for the window report
    logic div_start;  // start the average dividers
    logic load_per;   // load period report, clear period state
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic div_busy;
  } sts_t;

endpackage

FILE: design/slm_div.sv
// Bit-serial restoring divider: 14-bit sum by 6-bit divisor, one quotient
// bit per cycle. Depends on slm_pkg.
module slm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [slm_pkg::SUM_W-1:0]    dividend,
  input  logic [slm_pkg::LIM_W-1:0]    divisor,
  output logic                         busy,
  output logic [slm_pkg::SUM_W-1:0]    quotient
);

  logic [slm_pkg::SUM_W-1:0]   q_r;
  logic [slm_pkg::LIM_W-1:0]   rem_r;
  logic [slm_pkg::LIM_W-1:0]   dvs_r;
  logic [slm_pkg::DSTEP_W-1:0] cnt_r;
  logic                        busy_r;

  logic [slm_pkg::LIM_W:0]     trial;
  logic                        ge;
  logic [slm_pkg::LIM_W:0]     diff;
  logic [slm_pkg::LIM_W-1:0]   rem_nxt;

  // One restoring step
  always_comb begin
    trial   = {rem_r, q_r[slm_pkg::SUM_W-1]};
    ge      = (trial >= {1'b0, dvs_r});
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = ge ? diff[slm_pkg::LIM_W-1:0] : trial[slm_pkg::LIM_W-1:0];
  end

  // Iteration registers; zero divisor counts as one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      q_r    <= dividend;
      rem_r  <= '0;
      dvs_r  <= (divisor == '0) ? slm_pkg::LIM_W'(1) : divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[slm_pkg::SUM_W-2:0], ge};
      rem_r <= rem_nxt;
      if (cnt_r == slm_pkg::DSTEP_W'(slm_pkg::SUM_W - 1)) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

FILE: design/slm_dp.sv
// Datapath: config registers, window min/max, level scaling, period sums,
// direction/status, output register and average dividers.
// Depends on slm_pkg and slm_div.
module slm_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  slm_pkg::cmd_t                     cmd,
  output slm_pkg::sts_t                     sts,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [slm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [slm_pkg::LVL_W-1:0]         cfg_data,
  input  logic [slm_pkg::SMP_W-1:0]         in_sample_ch1,
  input  logic [slm_pkg::SMP_W-1:0]         in_sample_ch2,
  input  logic [slm_pkg::SMP_W-1:0]         in_sample_ch3,
  input  logic [slm_pkg::SMP_W-1:0]         in_sample_ch4,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_report_kind,
  output logic [slm_pkg::LVL_W-1:0]         out_level_ch1,
  output logic [slm_pkg::LVL_W-1:0]         out_level_ch2,
  output logic [slm_pkg::LVL_W-1:0]         out_level_ch3,
  output logic [slm_pkg::LVL_W-1:0]         out_level_ch4,
  output logic                              out_loud_status,
  output logic [slm_pkg::DIR_W-1:0]         out_direction,
  output logic                              out_last
);

  localparam int NCH = slm_pkg::NUM_CH;

  // Config registers
  logic [slm_pkg::LVL_W-1:0] floor_r, ceil_r, loud_lvl_r;
  logic [slm_pkg::LIM_W-1:0] limit_r, avg_div_r;

  // Window, period and pipeline state
  logic [slm_pkg::SMP_W-1:0]  max_r  [NCH];
  logic [slm_pkg::SMP_W-1:0]  min_r  [NCH];
  logic [slm_pkg::PROD_W-1:0] prod_r [NCH];
  logic [NCH-1:0]             empty_r;
  logic [slm_pkg::LVL_W-1:0]  lvl_r  [NCH];
  logic [slm_pkg::SUM_W-1:0]  sum_r  [NCH];
  logic [slm_pkg::CNT_W-1:0]  cnt_r;
  logic [slm_pkg::DIR_W-1:0]  dir_r;
  logic                       status_r;

  // Output register
  logic                       out_valid_r;
  logic                       kind_r;
  logic [slm_pkg::LVL_W-1:0]  olvl_r [NCH];
  logic                       ostatus_r;
  logic [slm_pkg::DIR_W-1:0]  odir_r;
  logic                       olast_r;

  logic [slm_pkg::SMP_W-1:0]  smp      [NCH];
  logic [slm_pkg::LVL_W-1:0]  span;
  logic [slm_pkg::PROD_W-1:0] prod_nxt [NCH];
  logic [slm_pkg::LVL_W-1:0]  lvl_nxt  [NCH];
  logic [slm_pkg::SUM_W-1:0]  sum_nxt  [NCH];
  logic [slm_pkg::LVL_W-1:0]  avg      [NCH];
  logic [slm_pkg::SUM_W-1:0]  quot     [NCH];
  logic [NCH-1:0]             busy;
  logic                       loud;
  logic                       top_found;
  logic [slm_pkg::DIR_W-1:0]  top_dir;
  logic                       status_nxt;
  logic [slm_pkg::DIR_W-1:0]  dir_nxt;

  assign smp[0] = in_sample_ch1;
  assign smp[1] = in_sample_ch2;
  assign smp[2] = in_sample_ch3;
  assign smp[3] = in_sample_ch4;

  assign cfg_ready = 1'b1;

  // Config writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r    <= slm_pkg::FLOOR_RST;
      ceil_r     <= slm_pkg::CEILING_RST;
      loud_lvl_r <= slm_pkg::LOUD_RST;
      limit_r    <= slm_pkg::LIMIT_RST;
      avg_div_r  <= slm_pkg::AVGDIV_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        slm_pkg::CFG_FLOOR:   floor_r    <= cfg_data;
        slm_pkg::CFG_CEILING: ceil_r     <= cfg_data;
        slm_pkg::CFG_LOUD:    loud_lvl_r <= cfg_data;
        slm_pkg::CFG_LIMIT:   limit_r    <= cfg_data[slm_pkg::LIM_W-1:0];
        slm_pkg::CFG_AVGDIV:  avg_div_r  <= cfg_data[slm_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Span of the level range; inverted range collapses to floor
  assign span = (ceil_r >= floor_r) ? (ceil_r - floor_r) : '0;

  // Peak-to-peak times span, then divide by full scale
  always_comb begin
    logic [slm_pkg::SMP_W-1:0]   pp;
    logic [slm_pkg::LVL_W-1:0]   q0;
    logic [slm_pkg::SMP_W:0]     r;
    logic [slm_pkg::LVL_W-1:0]   q;
    logic [slm_pkg::SUM_W:0]     s;
    for (int c = 0; c < NCH; c++) begin
      pp          = max_r[c] - min_r[c];
      prod_nxt[c] = {{slm_pkg::LVL_W{1'b0}}, pp} * {{slm_pkg::SMP_W{1'b0}}, span};
      // x / 4095: x >> 12 plus one correction step
      q0 = prod_r[c][slm_pkg::PROD_W-1:slm_pkg::SMP_W];
      r  = {1'b0, prod_r[c][slm_pkg::SMP_W-1:0]} + (slm_pkg::SMP_W+1)'(q0);
      q  = q0 + ((r >= {1'b0, slm_pkg::FULL_SCALE}) ? slm_pkg::LVL_W'(1) : '0);
      lvl_nxt[c] = empty_r[c] ? floor_r : floor_r + q;
      // Saturating sum
      s = {1'b0, sum_r[c]} + (slm_pkg::SUM_W+1)'(lvl_r[c]);
      sum_nxt[c] = s[slm_pkg::SUM_W] ? '1 : s[slm_pkg::SUM_W-1:0];
      avg[c] = (|quot[c][slm_pkg::SUM_W-1:slm_pkg::LVL_W]) ? '1
                                                           : quot[c][slm_pkg::LVL_W-1:0];
    end
  end

  // Loud window: any level above the threshold
  always_comb begin
    loud = 1'b0;
    for (int c = 0; c < NCH; c++) begin
      if (lvl_r[c] > loud_lvl_r) loud = 1'b1;
    end
  end

  // First channel whose sum strictly beats all others
  always_comb begin
    logic top;
    top_found = 1'b0;
    top_dir   = slm_pkg::DIR_UNDECIDED;
    for (int c = 0; c < NCH; c++) begin
      top = 1'b1;
      for (int k = 0; k < NCH; k++) begin
        if (k != c && sum_r[c] <= sum_r[k]) top = 1'b0;
      end
      if (top && !top_found) begin
        top_found = 1'b1;
        top_dir   = slm_pkg::DIR_CH_BASE + slm_pkg::DIR_W'(c);
      end
    end
    status_nxt = (cnt_r > {1'b0, limit_r});
    if (!status_nxt) begin
      dir_nxt = slm_pkg::DIR_QUIET;
    end else if (top_found) begin
      dir_nxt = top_dir;
    end else begin
      dir_nxt = dir_r;
    end
  end

  // Window min/max and level pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCH; c++) begin
        max_r[c] <= '0;
        min_r[c] <= slm_pkg::SPURIOUS;
      end
    end else if (cmd.mul) begin
      for (int c = 0; c < NCH; c++) begin
        prod_r[c]  <= prod_nxt[c];
        empty_r[c] <= (min_r[c] > max_r[c]);
        max_r[c]   <= '0;
        min_r[c]   <= slm_pkg::SPURIOUS;
      end
    end else if (cmd.capture) begin
      for (int c = 0; c < NCH; c++) begin
        if (smp[c] != slm_pkg::SPURIOUS) begin
          if (smp[c] > max_r[c]) max_r[c] <= smp[c];
          if (smp[c] < min_r[c]) min_r[c] <= smp[c];
        end
      end
    end
    if (cmd.lvl) begin
      for (int c = 0; c < NCH; c++) lvl_r[c] <= lvl_nxt[c];
    end
  end

  // Period state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCH; c++) sum_r[c] <= '0;
      cnt_r    <= '0;
      dir_r    <= slm_pkg::DIR_UNDECIDED;
      status_r <= 1'b0;
    end else if (cmd.load_per) begin
      for (int c = 0; c < NCH; c++) sum_r[c] <= '0;
      cnt_r    <= '0;
      dir_r    <= slm_pkg::DIR_UNDECIDED;
      status_r <= 1'b0;
    end else if (cmd.sum) begin
      for (int c = 0; c < NCH; c++) sum_r[c] <= sum_nxt[c];
      if (loud && cnt_r != '1) cnt_r <= cnt_r + 1'b1;
    end else if (cmd.dir) begin
      dir_r    <= dir_nxt;
      status_r <= status_nxt;
    end
  end

  // Period averages, one divider per channel
  for (genvar g = 0; g < NCH; g++) begin : g_div
    slm_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (cmd.div_start),
      .dividend (sum_r[g]),
      .divisor  (avg_div_r),
      .busy     (busy[g]),
      .quotient (quot[g])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_win || cmd.load_per) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_win) begin
      kind_r    <= slm_pkg::KIND_WINDOW;
      for (int c = 0; c < NCH; c++) olvl_r[c] <= lvl_r[c];
      ostatus_r <= status_r;
      odir_r    <= dir_r;
      olast_r   <= cmd.last;
    end else if (cmd.load_per) begin
      kind_r    <= slm_pkg::KIND_PERIOD;
      for (int c = 0; c < NCH; c++) olvl_r[c] <= avg[c];
      ostatus_r <= status_r;
      odir_r    <= dir_r;
      olast_r   <= 1'b1;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.div_busy = |busy;

  assign out_valid       = out_valid_r;
  assign out_report_kind = kind_r;
  assign out_level_ch1   = olvl_r[0];
  assign out_level_ch2   = olvl_r[1];
  assign out_level_ch3   = olvl_r[2];
  assign out_level_ch4   = olvl_r[3];
  assign out_loud_status = ostatus_r;
  assign out_direction   = odir_r;
  assign out_last        = olast_r;

endmodule

FILE: design/slm_ctrl.sv
// Controller: sequences window close and period close steps of the datapath.
// Depends on slm_pkg.
module slm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_window_end,
  input  logic           in_period_end,
  output logic           in_stall,
  input  slm_pkg::sts_t  sts,
  output slm_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_LVL, S_SUM, S_DIR, S_WOUT, S_DIV, S_DWAIT, S_POUT
  } state_t;

  state_t state_r;
  logic   pend_r;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // State and period-close flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_window_end || in_period_end)) begin
            state_r <= S_MUL;
            pend_r  <= in_period_end;
          end
        end
        S_MUL:  state_r <= S_LVL;
        S_LVL:  state_r <= S_SUM;
        S_SUM:  state_r <= S_DIR;
        S_DIR:  state_r <= S_WOUT;
        S_WOUT: begin
          if (sts.out_free) state_r <= pend_r ? S_DIV : S_IDLE;
        end
        S_DIV:  state_r <= S_DWAIT;
        S_DWAIT: begin
          if (!sts.div_busy) state_r <= S_POUT;
        end
        S_POUT: begin
          if (sts.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Command decode
  always_comb begin
    cmd           = '0;
    cmd.capture   = accept;
    cmd.mul       = (state_r == S_MUL);
    cmd.lvl       = (state_r == S_LVL);
    cmd.sum       = (state_r == S_SUM);
    cmd.dir       = (state_r == S_DIR);
    cmd.load_win  = (state_r == S_WOUT) && sts.out_free;
    cmd.last      = !pend_r;
    cmd.div_start = (state_r == S_DIV);
    cmd.load_per  = (state_r == S_POUT) && sts.out_free;
  end

endmodule

FILE: design/four_channel_sound_level_monitor.sv
// Top level of the four-channel sound level monitor.
// Depends on slm_pkg, slm_ctrl, slm_dp (and slm_div through slm_dp).

// Takes one beat of four 12-bit samples per clock while no window is
// closing. A beat with window_end or period_end stalls the input while
// the close steps run (product, scale, sum, decision, report load), and
// longer if the output is held. A period close then adds the 14-step
// bit-serial average dividers and the period report. The output register
// lets the next beat be taken while a report waits. Config writes are taken
// in any cycle (cfg_ready is tied high) and are meant for idle periods.
module four_channel_sound_level_monitor (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [slm_pkg::SMP_W-1:0]        in_sample_ch1,
  input  logic [slm_pkg::SMP_W-1:0]        in_sample_ch2,
  input  logic [slm_pkg::SMP_W-1:0]        in_sample_ch3,
  input  logic [slm_pkg::SMP_W-1:0]        in_sample_ch4,
  input  logic                             in_window_end,
  input  logic                             in_period_end,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_report_kind,
  output logic [slm_pkg::LVL_W-1:0]        out_level_ch1,
  output logic [slm_pkg::LVL_W-1:0]        out_level_ch2,
  output logic [slm_pkg::LVL_W-1:0]        out_level_ch3,
  output logic [slm_pkg::LVL_W-1:0]        out_level_ch4,
  output logic                             out_loud_status,
  output logic [slm_pkg::DIR_W-1:0]        out_direction,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slm_pkg::LVL_W-1:0]        cfg_data
);

  slm_pkg::cmd_t cmd;
  slm_pkg::sts_t sts;

  // Sequencer
  slm_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_window_end (in_window_end),
    .in_period_end (in_period_end),
    .in_stall      (in_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  // Datapath
  slm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_sample_ch1   (in_sample_ch1),
    .in_sample_ch2   (in_sample_ch2),
    .in_sample_ch3   (in_sample_ch3),
    .in_sample_ch4   (in_sample_ch4),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_report_kind (out_report_kind),
    .out_level_ch1   (out_level_ch1),
    .out_level_ch2   (out_level_ch2),
    .out_level_ch3   (out_level_ch3),
    .out_level_ch4   (out_level_ch4),
    .out_loud_status (out_loud_status),
    .out_direction   (out_direction),
    .out_last        (out_last)
  );

endmodule

FILE: design/slm_chk.sv
// Port-level checker for the sound level monitor, bound to the top level.
// Depends on slm_pkg.
module slm_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [slm_pkg::SMP_W-1:0]        in_sample_ch1,
  input logic [slm_pkg::SMP_W-1:0]        in_sample_ch2,
  input logic [slm_pkg::SMP_W-1:0]        in_sample_ch3,
  input logic [slm_pkg::SMP_W-1:0]        in_sample_ch4,
  input logic                             in_window_end,
  input logic                             in_period_end,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             out_report_kind,
  input logic [slm_pkg::LVL_W-1:0]        out_level_ch1,
  input logic [slm_pkg::LVL_W-1:0]        out_level_ch2,
  input logic [slm_pkg::LVL_W-1:0]        out_level_ch3,
  input logic [slm_pkg::LVL_W-1:0]        out_level_ch4,
  input logic                             out_loud_status,
  input logic [slm_pkg::DIR_W-1:0]        out_direction,
  input logic                             out_last,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [slm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [slm_pkg::LVL_W-1:0]        cfg_data
);

  // Held report beat keeps valid, its kind, last flag and channel 1 level
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_level_ch1)
      && $stable(out_report_kind) && $stable(out_last))
    else $error("held report beat changed");

  // A period report always closes the beat's results
  a_period_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_report_kind == slm_pkg::KIND_PERIOD) |-> out_last)
    else $error("period report without last");

  // Quiet status forces the quiet direction
  a_quiet_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_loud_status |-> out_direction == slm_pkg::DIR_QUIET)
    else $error("quiet report with non-quiet direction");

  // Closing beat starts the close sequence
  a_close_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_window_end || in_period_end) |=> in_stall)
    else $error("no stall after closing beat");

  // Plain sample beats stream at one per cycle
  a_plain_rate: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_window_end && !in_period_end |=> !in_stall)
    else $error("stall after plain sample beat");

endmodule

bind four_channel_sound_level_monitor slm_chk u_slm_chk (.*);

FILE: verif/tb_four_channel_sound_level_monitor.sv
// Self-checking testbench for four_channel_sound_level_monitor.
// Depends on slm_pkg and the design; runs a directed table, then random phases
// under several register settings, and checks every report against a predictor or typed-in values.
`timescale 1ns / 1ps

module tb_four_channel_sound_level_monitor;

  localparam int DRAIN_CYCLES = 40;       // window close + divider + report, with margin
  localparam int SUM_MAX      = (1 << slm_pkg::SUM_W) - 1;
  localparam int CNT_MAX      = (1 << slm_pkg::CNT_W) - 1;
  localparam logic [slm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // one input beat and one report beat
  typedef struct packed {
    logic [slm_pkg::NUM_CH-1:0][slm_pkg::SMP_W-1:0] smp;
    logic                                           win_end;
    logic                                           per_end;
  } beat_t;

  typedef struct packed {
    logic                                           kind;
    logic [slm_pkg::NUM_CH-1:0][slm_pkg::LVL_W-1:0] lvl;
    logic                                           loud;
    logic [slm_pkg::DIR_W-1:0]                      dir;
    logic                                           last;
  } report_t;

  // directed table row: either a beat (with optional typed-in reports) or a register write
  typedef struct {
    bit                            is_cfg;
    beat_t                         b;
    logic [slm_pkg::CFG_IDX_W-1:0] idx;
    logic [slm_pkg::LVL_W-1:0]     val;
    int                            n_lit;
    report_t                       lit0;
    report_t                       lit1;
  } row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [slm_pkg::SMP_W-1:0]     in_sample_ch1 = '0;
  logic [slm_pkg::SMP_W-1:0]     in_sample_ch2 = '0;
  logic [slm_pkg::SMP_W-1:0]     in_sample_ch3 = '0;
  logic [slm_pkg::SMP_W-1:0]     in_sample_ch4 = '0;
  logic                          in_window_end = 1'b0;
  logic                          in_period_end = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_report_kind;
  logic [slm_pkg::LVL_W-1:0]     out_level_ch1;
  logic [slm_pkg::LVL_W-1:0]     out_level_ch2;
  logic [slm_pkg::LVL_W-1:0]     out_level_ch3;
  logic [slm_pkg::LVL_W-1:0]     out_level_ch4;
  logic                          out_loud_status;
  logic [slm_pkg::DIR_W-1:0]     out_direction;
  logic                          out_last;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [slm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [slm_pkg::LVL_W-1:0]     cfg_data = '0;

  // predictor copy of configuration and state
  int unsigned r_floor, r_ceiling, r_loud, r_limit, r_avgdiv;
  int unsigned ch_max [slm_pkg::NUM_CH];
  int unsigned ch_min [slm_pkg::NUM_CH];
  int unsigned lvl_sum [slm_pkg::NUM_CH];
  int unsigned loud_cnt;
  logic [slm_pkg::DIR_W-1:0] dir_st;
  logic                      status_st;

  report_t pending_reports [$];
  row_t    dir_rows [$];

  int err_cnt = 0;
  int beats_sent = 0;
  int win_seen = 0;
  int per_seen = 0;
  int cfg_writes = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;

  four_channel_sound_level_monitor u_top (.*);

  always #4 clk = ~clk;

  // safety net
  initial begin
    #2_000_000;
    $display("Timeout with %0d reports outstanding", pending_reports.size());
    $display("FAILED: results differ");
    $finish;
  end

  function automatic report_t mk_report(input logic kind,
                                        input logic [slm_pkg::LVL_W-1:0] lvl,
                                        input logic loud,
                                        input logic [slm_pkg::DIR_W-1:0] dir,
                                        input logic last);
    report_t r;
    r.kind = kind;
    for (int c = 0; c < slm_pkg::NUM_CH; c++) r.lvl[c] = lvl;
    r.loud = loud;
    r.dir  = dir;
    r.last = last;
    return r;
  endfunction

  // mostly random, weighted toward the spurious code and the extremes
  function automatic logic [slm_pkg::SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return slm_pkg::SPURIOUS;
      1: return '0;
      2: return slm_pkg::SPURIOUS - 1'b1;
      default: return slm_pkg::SMP_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // table builders
  task automatic add_beat(input int s1, input int s2, input int s3, input int s4,
                          input bit w, input bit p);
    row_t r;
    r = '{default: '0};
    r.b.smp[0] = slm_pkg::SMP_W'(s1);
    r.b.smp[1] = slm_pkg::SMP_W'(s2);
    r.b.smp[2] = slm_pkg::SMP_W'(s3);
    r.b.smp[3] = slm_pkg::SMP_W'(s4);
    r.b.win_end = w;
    r.b.per_end = p;
    dir_rows.push_back(r);
  endtask

  task automatic add_cfg(input logic [slm_pkg::CFG_IDX_W-1:0] idx,
                         input logic [slm_pkg::LVL_W-1:0] val);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    dir_rows.push_back(r);
  endtask

  task automatic add_lit(input report_t rep);
    int k;
    k = dir_rows.size() - 1;
    if (dir_rows[k].n_lit == 0) dir_rows[k].lit0 = rep;
    else dir_rows[k].lit1 = rep;
    dir_rows[k].n_lit++;
  endtask

  // level tracking for one beat; yields the reports it causes
  task automatic compute_reports(input beat_t b, output int n,
                                 output report_t win_rep, output report_t per_rep);
    int unsigned span, pp, lv, dv, av;
    bit loud, top, found;
    n = 0;
    win_rep = '0;
    per_rep = '0;
    for (int c = 0; c < slm_pkg::NUM_CH; c++) begin
      if (b.smp[c] != slm_pkg::SPURIOUS) begin
        if (b.smp[c] > ch_max[c]) ch_max[c] = b.smp[c];
        if (b.smp[c] < ch_min[c]) ch_min[c] = b.smp[c];
      end
    end
    if (!b.win_end && !b.per_end) return;

    // window levels, sums, loudness
    loud = 0;
    span = (r_ceiling >= r_floor) ? r_ceiling - r_floor : 0;
    for (int c = 0; c < slm_pkg::NUM_CH; c++) begin
      if (ch_min[c] > ch_max[c]) begin
        lv = r_floor;
      end else begin
        pp = ch_max[c] - ch_min[c];
        lv = r_floor + (pp * span) / 4095;
      end
      lvl_sum[c] = (lvl_sum[c] + lv > SUM_MAX) ? SUM_MAX : lvl_sum[c] + lv;
      if (lv > r_loud) loud = 1;
      win_rep.lvl[c] = slm_pkg::LVL_W'(lv);
      ch_max[c] = 0;
      ch_min[c] = slm_pkg::SPURIOUS;
    end

    // strictly largest sum wins; a tie keeps the old direction
    found = 0;
    for (int c = 0; c < slm_pkg::NUM_CH; c++) begin
      top = 1;
      for (int k = 0; k < slm_pkg::NUM_CH; k++)
        if (k != c && lvl_sum[c] <= lvl_sum[k]) top = 0;
      if (top && !found) begin
        dir_st = slm_pkg::DIR_CH_BASE + slm_pkg::DIR_W'(c);
        found = 1;
      end
    end

    if (loud && loud_cnt < CNT_MAX) loud_cnt++;
    if (loud_cnt > r_limit) begin
      status_st = 1'b1;
    end else begin
      status_st = 1'b0;
      dir_st = slm_pkg::DIR_QUIET;
    end
    win_rep.kind = slm_pkg::KIND_WINDOW;
    win_rep.loud = status_st;
    win_rep.dir  = dir_st;
    win_rep.last = !b.per_end;
    n = 1;

    // period averages, then period state clears
    if (b.per_end) begin
      dv = (r_avgdiv == 0) ? 1 : r_avgdiv;
      for (int c = 0; c < slm_pkg::NUM_CH; c++) begin
        av = lvl_sum[c] / dv;
        per_rep.lvl[c] = slm_pkg::LVL_W'((av > 255) ? 255 : av);
        lvl_sum[c] = 0;
      end
      per_rep.kind = slm_pkg::KIND_PERIOD;
      per_rep.loud = status_st;
      per_rep.dir  = dir_st;
      per_rep.last = 1'b1;
      n = 2;
      loud_cnt = 0;
      dir_st = slm_pkg::DIR_UNDECIDED;
      status_st = 1'b0;
    end
  endtask

  // input side is idle: random payload, valid low
  task automatic go_idle();
    in_valid <= 1'b0;
    in_sample_ch1 <= slm_pkg::SMP_W'($urandom_range(0, 4095));
    in_sample_ch2 <= slm_pkg::SMP_W'($urandom_range(0, 4095));
    in_sample_ch3 <= slm_pkg::SMP_W'($urandom_range(0, 4095));
    in_sample_ch4 <= slm_pkg::SMP_W'($urandom_range(0, 4095));
    in_window_end <= 1'($urandom_range(0, 1));
    in_period_end <= 1'($urandom_range(0, 1));
  endtask

  // present one beat until taken, then record its reports
  task automatic send_beat(input beat_t b, input int n_lit,
                           input report_t lit0, input report_t lit1);
    int n;
    report_t p0, p1;
    in_valid <= 1'b1;
    in_sample_ch1 <= b.smp[0];
    in_sample_ch2 <= b.smp[1];
    in_sample_ch3 <= b.smp[2];
    in_sample_ch4 <= b.smp[3];
    in_window_end <= b.win_end;
    in_period_end <= b.per_end;
    do @(posedge clk); while (in_stall);
    compute_reports(b, n, p0, p1);
    if (n_lit > 0) begin
      pending_reports.push_back(lit0);
      if (n_lit > 1) pending_reports.push_back(lit1);
    end else begin
      if (n > 0) pending_reports.push_back(p0);
      if (n > 1) pending_reports.push_back(p1);
    end
    beats_sent++;
  endtask

  // each cycle idles with the sender's idle odds
  task automatic maybe_gap();
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      go_idle();
      @(posedge clk);
    end
  endtask

  // hold off input until every report is out and the block has settled
  task automatic drain();
    go_idle();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [slm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [slm_pkg::LVL_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      slm_pkg::CFG_FLOOR:   r_floor   = val;
      slm_pkg::CFG_CEILING: r_ceiling = val;
      slm_pkg::CFG_LOUD:    r_loud    = val;
      slm_pkg::CFG_LIMIT:   r_limit   = val[slm_pkg::LIM_W-1:0];
      slm_pkg::CFG_AVGDIV:  r_avgdiv  = val[slm_pkg::LIM_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // report monitor and receiver stall
  always @(posedge clk) begin : report_monitor
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (out_report_kind == slm_pkg::KIND_PERIOD) per_seen++;
      else win_seen++;
      if (pending_reports.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected report, expected none, actual kind %0d levels %0d %0d %0d %0d",
                 $time, out_report_kind, out_level_ch1, out_level_ch2, out_level_ch3,
                 out_level_ch4);
      end else begin
        want = pending_reports.pop_front();
        check_field("report_kind", want.kind, out_report_kind);
        check_field("level_ch1", want.lvl[0], out_level_ch1);
        check_field("level_ch2", want.lvl[1], out_level_ch2);
        check_field("level_ch3", want.lvl[2], out_level_ch3);
        check_field("level_ch4", want.lvl[3], out_level_ch4);
        check_field("loud_status", want.loud, out_loud_status);
        check_field("direction", want.dir, out_direction);
        check_field("last", want.last, out_last);
      end
    end
    out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  initial begin : stimulus
    beat_t b;
    int n_items, wpct, ppct;
    logic [slm_pkg::LVL_W-1:0] v_floor, v_ceiling, v_loud, v_limit, v_div;

    // predictor reset state
    r_floor = slm_pkg::FLOOR_RST;
    r_ceiling = slm_pkg::CEILING_RST;
    r_loud = slm_pkg::LOUD_RST;
    r_limit = slm_pkg::LIMIT_RST;
    r_avgdiv = slm_pkg::AVGDIV_RST;
    for (int c = 0; c < slm_pkg::NUM_CH; c++) begin
      ch_max[c] = 0;
      ch_min[c] = slm_pkg::SPURIOUS;
      lvl_sum[c] = 0;
    end
    loud_cnt = 0;
    dir_st = slm_pkg::DIR_UNDECIDED;
    status_st = 1'b0;

    // directed table, reset settings first
    add_beat(0, 0, 0, 0, 0, 0);
    add_beat(4094, 4094, 4094, 4094, 1, 0);   // full swing on every channel
    add_lit(mk_report(slm_pkg::KIND_WINDOW, 8'd149, 1'b0, slm_pkg::DIR_QUIET, 1'b1));
    add_beat(4095, 4095, 4095, 4095, 1, 0);   // window of spurious samples only
    add_lit(mk_report(slm_pkg::KIND_WINDOW, 8'd30, 1'b0, slm_pkg::DIR_QUIET, 1'b1));
    add_beat(0, 100, 4095, 2048, 0, 0);
    add_beat(4094, 100, 4095, 0, 1, 0);
    add_beat(1, 2, 3, 4, 0, 1);               // period end without window end
    add_beat(4095, 4095, 4095, 4095, 0, 1);   // fresh period, floor levels
    add_lit(mk_report(slm_pkg::KIND_WINDOW, 8'd30, 1'b0, slm_pkg::DIR_QUIET, 1'b0));
    add_lit(mk_report(slm_pkg::KIND_PERIOD, 8'd1, 1'b0, slm_pkg::DIR_QUIET, 1'b1));
    // loud from the first loud window on
    add_cfg(slm_pkg::CFG_LIMIT, 8'd0);
    add_cfg(CFG_UNUSED, 8'hff);
    add_beat(0, 0, 0, 0, 0, 0);
    add_beat(4094, 2000, 1000, 4095, 1, 0);
    add_beat(0, 4094, 0, 0, 1, 0);
    add_beat(0, 0, 0, 0, 0, 0);
    add_beat(2000, 0, 4095, 4095, 1, 0);      // ch1 keeps the strictly largest sum
    // ceiling under floor, divisor zero
    add_cfg(slm_pkg::CFG_FLOOR, 8'd200);
    add_cfg(slm_pkg::CFG_CEILING, 8'd100);
    add_cfg(slm_pkg::CFG_AVGDIV, 8'd0);
    add_beat(0, 0, 0, 0, 0, 0);
    add_beat(4094, 4094, 4094, 4094, 1, 1);   // both end flags, averages saturate

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        write_reg(dir_rows[k].idx, dir_rows[k].val);
      end else begin
        send_beat(dir_rows[k].b, dir_rows[k].n_lit, dir_rows[k].lit0, dir_rows[k].lit1);
        maybe_gap();
      end
    end

    // random phases, one register setting and one idling mode each
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          v_floor = 0; v_ceiling = 255; v_loud = 128; v_limit = 0; v_div = 63;
          n_items = 80; wpct = 15; ppct = 4;
          snd_idle_pct = 0; rcv_stall_pct = 0;
        end
        1, 3: begin
          v_floor = slm_pkg::LVL_W'($urandom_range(0, 255));
          v_ceiling = slm_pkg::LVL_W'($urandom_range(0, 255));
          v_loud = slm_pkg::LVL_W'($urandom_range(0, 255));
          v_limit = slm_pkg::LVL_W'($urandom_range(0, 255));
          v_div = slm_pkg::LVL_W'($urandom_range(0, 255));
          n_items = 90; wpct = 20; ppct = 5;
          snd_idle_pct = (ph == 1) ? 46 : 37;
          rcv_stall_pct = (ph == 1) ? 0 : 37;
        end
        2: begin
          // every beat closes a window: sums and loud count saturate
          v_floor = 255; v_ceiling = 255; v_loud = 0; v_limit = 63; v_div = 1;
          n_items = 140; wpct = 100; ppct = 0;
          snd_idle_pct = 0; rcv_stall_pct = 46;
        end
        default: begin
          v_floor = 10; v_ceiling = 0; v_loud = 255; v_limit = 5; v_div = 7;
          n_items = 50; wpct = 25; ppct = 8;
          snd_idle_pct = 37; rcv_stall_pct = 37;
        end
      endcase
      write_reg(slm_pkg::CFG_FLOOR, v_floor);
      write_reg(slm_pkg::CFG_CEILING, v_ceiling);
      write_reg(slm_pkg::CFG_LOUD, v_loud);
      write_reg(slm_pkg::CFG_LIMIT, v_limit);
      write_reg(slm_pkg::CFG_AVGDIV, v_div);

      for (int i = 0; i < n_items; i++) begin
        for (int c = 0; c < slm_pkg::NUM_CH; c++) b.smp[c] = rand_sample();
        b.win_end = ($urandom_range(0, 99) < wpct);
        b.per_end = ($urandom_range(0, 99) < ppct) || (i == n_items - 1);
        send_beat(b, 0, '0, '0);
        if ($urandom_range(0, 59) == 0) drain();
        else maybe_gap();
      end
    end

    drain();
    $display("Covered %0d beats, %0d window and %0d period reports, %0d register writes",
             beats_sent, win_seen, per_seen, cfg_writes);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
